@@ src/led_pkg.sv @@
package led_pkg;

    localparam int LineLen   = 32;
    localparam int HistDepth = 10;

    localparam logic [7:0] EscTimeoutReset = 8'd10;

    localparam logic [7:0] ChBel = 8'h07;
    localparam logic [7:0] ChBs  = 8'h08;
    localparam logic [7:0] ChLf  = 8'h0A;
    localparam logic [7:0] ChCr  = 8'h0D;
    localparam logic [7:0] ChEsc = 8'h1B;
    localparam logic [7:0] ChSp  = 8'h20;
    localparam logic [7:0] ChDel = 8'h7F;
    localparam logic [7:0] ChLbr = 8'h5B;
    localparam logic [7:0] ChAt  = 8'h40;
    localparam logic [7:0] ChTil = 8'h7E;
    localparam logic [7:0] ChUp  = 8'h41;
    localparam logic [7:0] ChDn  = 8'h42;
    localparam logic [7:0] ChGt  = 8'h3E;

    // classified operation handed from the front to the back
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_CHAR  = 3'd1,
        OP_BKSP  = 3'd2,
        OP_ENTER = 3'd3,
        OP_UP    = 3'd4,
        OP_DOWN  = 3'd5
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    function automatic logic [7:0] erase_prompt(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = ChCr;
            3'd1:    b = ChEsc;
            3'd2:    b = ChLbr;
            3'd3:    b = 8'h30;
            3'd4:    b = 8'h4B;
            default: b = ChGt;
        endcase
        return b;
    endfunction

endpackage

@@ src/led_ram.sv @@
module led_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ src/led_front.sv @@
module led_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_action,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_q_valid,
    input  logic                 i_q_stall,
    output led_pkg::t_cmd        o_q_cmd
);
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_ESC  = 3'b010,
        PH_SEQ  = 3'b100
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [7:0]    r_ticks, n_ticks;
    logic [7:0]    r_tmo;
    logic [1:0]    r_cnt;
    led_pkg::t_cmd r_q [2];
    logic          r_rd, r_wr;
    led_pkg::t_cmd n_cmd;
    logic          acc, push, pop;
    t_phase        ph;

    // two-entry queue; stall when full
    assign o_stall   = (r_cnt == 2'd2);
    assign acc       = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rd];
    assign pop       = o_q_valid && !i_q_stall;

    always_comb begin
        n_phase = r_phase;
        n_ticks = r_ticks;
        n_cmd   = '{op: led_pkg::OP_NONE, data: i_rx_byte};
        ph      = r_phase;
        if (i_action) begin
            if (r_phase != PH_IDLE && r_ticks != 8'hFF) begin
                n_ticks = r_ticks + 8'd1;
            end
        end else begin
            if (r_phase != PH_IDLE && r_ticks > r_tmo) begin
                ph = PH_IDLE;
            end
            n_phase = ph;
            unique case (ph)
                PH_IDLE: begin
                    if (i_rx_byte == led_pkg::ChCr || i_rx_byte == led_pkg::ChLf) begin
                        n_cmd.op = led_pkg::OP_ENTER;
                    end else if (i_rx_byte == led_pkg::ChDel || i_rx_byte == led_pkg::ChBs) begin
                        n_cmd.op = led_pkg::OP_BKSP;
                    end else if (i_rx_byte == led_pkg::ChEsc) begin
                        n_phase = PH_ESC;
                        n_ticks = 8'd0;
                    end else if (i_rx_byte >= led_pkg::ChSp && i_rx_byte != led_pkg::ChDel) begin
                        n_cmd.op = led_pkg::OP_CHAR;
                    end
                end
                PH_ESC: begin
                    n_phase = (i_rx_byte == led_pkg::ChLbr) ? PH_SEQ : PH_IDLE;
                end
                PH_SEQ: begin
                    if (i_rx_byte >= led_pkg::ChAt && i_rx_byte <= led_pkg::ChTil) begin
                        n_phase = PH_IDLE;
                        if (i_rx_byte == led_pkg::ChUp) n_cmd.op = led_pkg::OP_UP;
                        else if (i_rx_byte == led_pkg::ChDn) n_cmd.op = led_pkg::OP_DOWN;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // every byte goes through the queue so a silent one still orders behind busy work
    assign push = acc && !i_action;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ticks <= 8'd0;
            r_tmo   <= led_pkg::EscTimeoutReset;
            r_cnt   <= 2'd0;
            r_rd    <= 1'b0;
            r_wr    <= 1'b0;
        end else begin
            if (i_cfg_we) r_tmo <= i_cfg_wdata;
            if (acc) begin
                r_phase <= n_phase;
                r_ticks <= n_ticks;
            end
            if (push) r_wr <= !r_wr;
            if (pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= n_cmd;
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    a_nopush_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !push) else $error("push into full queue");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_phase))
        else $error("phase not one-hot");
endmodule

@@ src/led_back.sv @@
module led_back #(
    parameter int LineLen   = led_pkg::LineLen,
    parameter int HistDepth = led_pkg::HistDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    output logic          o_q_stall,
    input  led_pkg::t_cmd i_q_cmd,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_out_kind,
    output logic          o_cmd_end,
    output logic          o_last
);
    localparam int LW = $clog2(LineLen);
    localparam int HW = $clog2(HistDepth);
    localparam int AW = $clog2(HistDepth * LineLen);
    localparam logic [LW-1:0] LMax = LW'(LineLen - 1);
    localparam logic [HW-1:0] HMax = HW'(HistDepth - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_EMIT  = 8'b00000010,
        S_PRE   = 8'b00000100,
        S_CMD   = 8'b00001000,
        S_RDL   = 8'b00010000,
        S_PROMPT= 8'b00100000,
        S_RDH   = 8'b01000000,
        S_COPY  = 8'b10000000
    } t_state;

    t_state        r_st;
    led_pkg::t_cmd r_cmd;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_n;
    logic [LW-1:0] r_i;
    logic [2:0]    r_k;
    logic [HW-1:0] r_newest, r_view, r_slot;
    logic [LW-1:0] r_hlen [HistDepth];
    logic [HistDepth-1:0] r_hval;
    logic          r_ov;
    logic [7:0]    r_ob;
    logic          r_ok, r_oe, r_ol;

    logic          l_we;
    logic [LW-1:0] l_wa, l_ra;
    logic [7:0]    l_wd, l_rd;
    logic          h_we;
    logic [AW-1:0] h_wa, h_ra;
    logic [LW-1:0] h_ri;
    logic [7:0]    h_rd;
    logic          ofree;
    logic [HW-1:0] nxt_new, prv_view, nxt_view;
    logic [LW-1:0] hl_view, hl_nv;

    assign ofree = !r_ov || !i_stall;
    assign o_valid = r_ov;
    assign o_out_byte = r_ob;
    assign o_out_kind = r_ok;
    assign o_cmd_end = r_oe;
    assign o_last = r_ol;
    assign o_q_stall = (r_st != S_IDLE);

    assign nxt_new  = (r_newest == HMax) ? '0 : r_newest + 1'b1;
    assign prv_view = (r_view == '0) ? HMax : r_view - 1'b1;
    assign nxt_view = (r_view == HMax) ? '0 : r_view + 1'b1;
    assign hl_view  = r_hval[r_view] ? r_hlen[r_view] : '0;
    assign hl_nv    = r_hval[nxt_view] ? r_hlen[nxt_view] : '0;

    led_ram #(.Width(8), .Depth(LineLen)) u_line (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_wa), .i_wdata(l_wd),
        .i_raddr(l_ra), .o_rdata(l_rd)
    );
    led_ram #(.Width(8), .Depth(HistDepth * LineLen)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(l_rd),
        .i_raddr(h_ra), .o_rdata(h_rd)
    );

    // line reads run one ahead of use and hold the current byte while stalled
    // history address is slot*len + index
    assign l_ra = (r_st == S_IDLE) ? '0 :
                  (r_st == S_CMD && ofree) ? r_i : r_i - 1'b1;
    assign h_ri = (r_st == S_COPY && !ofree) ? r_i - 1'b1 : r_i;
    assign h_ra = AW'(r_slot) * AW'(LineLen) + AW'(h_ri);
    assign h_wa = AW'(r_newest) * AW'(LineLen) + AW'(r_i - 1'b1);
    assign h_we = (r_st == S_CMD) && ofree;
    assign l_we = (r_st == S_IDLE && i_q_valid && i_q_cmd.op == led_pkg::OP_CHAR
                   && r_len != LMax) || (r_st == S_COPY && ofree);
    assign l_wa = (r_st == S_COPY) ? r_i - 1'b1 : r_len;
    assign l_wd = (r_st == S_COPY) ? h_rd : i_q_cmd.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_len <= '0; r_newest <= '0; r_view <= '0;
            r_hval <= '0; r_ov <= 1'b0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_q_valid) begin
                    r_cmd <= i_q_cmd;
                    r_k <= 3'd0;
                    r_i <= '0;
                    case (i_q_cmd.op)
                        led_pkg::OP_CHAR: if (r_len != LMax) begin
                            r_len <= r_len + 1'b1; r_n <= '0; r_st <= S_EMIT;
                        end
                        led_pkg::OP_BKSP: if (r_len != '0) begin
                            r_len <= r_len - 1'b1; r_n <= LW'(2); r_st <= S_EMIT;
                        end
                        led_pkg::OP_ENTER: begin
                            if (r_len == '0) begin
                                r_n <= '0; r_st <= S_EMIT;
                            end else begin
                                r_n <= r_len; r_newest <= nxt_new; r_view <= nxt_new;
                                r_hlen[nxt_new] <= r_len; r_hval[nxt_new] <= 1'b1;
                                r_st <= S_PRE; r_i <= LW'(1);
                            end
                        end
                        led_pkg::OP_UP: begin
                            if (prv_view == r_newest || hl_view == '0) begin
                                r_n <= '0; r_st <= S_EMIT;
                            end else begin
                                r_slot <= r_view; r_n <= hl_view;
                                r_view <= prv_view; r_len <= hl_view;
                                r_st <= S_PROMPT;
                            end
                        end
                        led_pkg::OP_DOWN: begin
                            r_len <= '0;
                            r_n <= '0;
                            if (r_view != r_newest) begin
                                r_view <= nxt_view; r_slot <= nxt_view;
                                r_n <= hl_nv; r_len <= hl_nv;
                            end
                            r_st <= (r_view == r_newest) ? S_EMIT : S_PROMPT;
                        end
                        default: ;
                    endcase
                end
                // single result or bell, or backspace triple
                S_EMIT: if (ofree) begin
                    r_ov <= 1'b1; r_ok <= 1'b0; r_oe <= 1'b0;
                    if (r_cmd.op == led_pkg::OP_CHAR) begin
                        r_ob <= r_cmd.data; r_ol <= 1'b1; r_st <= S_IDLE;
                    end else if (r_cmd.op == led_pkg::OP_BKSP) begin
                        r_ob <= (r_k == 3'd1) ? led_pkg::ChSp : led_pkg::ChBs;
                        r_ol <= (r_k == 3'd2); r_k <= r_k + 3'd1;
                        if (r_k == 3'd2) r_st <= S_IDLE;
                    end else begin
                        // bell, then for down the erase prompt
                        r_ob <= led_pkg::ChBel;
                        r_ol <= (r_cmd.op != led_pkg::OP_DOWN);
                        r_st <= (r_cmd.op == led_pkg::OP_DOWN) ? S_PROMPT : S_IDLE;
                    end
                end
                S_PRE: if (ofree) begin
                    r_ov <= 1'b1; r_ok <= 1'b0; r_oe <= 1'b0; r_ol <= 1'b0;
                    r_ob <= (r_k == 3'd0) ? led_pkg::ChCr : led_pkg::ChLf;
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd1) r_st <= S_CMD;
                end
                S_CMD: if (ofree) begin
                    r_ov <= 1'b1; r_ok <= 1'b1; r_ob <= l_rd; r_ol <= 1'b0;
                    r_oe <= (r_i == r_n);
                    r_i <= r_i + 1'b1;
                    if (r_i == r_n) begin
                        r_st <= S_RDL;
                    end
                end
                S_RDL: if (ofree) begin
                    r_ov <= 1'b1; r_ok <= 1'b0; r_oe <= 1'b0; r_ol <= 1'b1;
                    r_ob <= led_pkg::ChGt; r_len <= '0; r_st <= S_IDLE;
                end
                S_PROMPT: if (ofree) begin
                    r_ov <= 1'b1; r_ok <= 1'b0; r_oe <= 1'b0;
                    r_ob <= led_pkg::erase_prompt(r_k);
                    r_ol <= (r_k == 3'd5) && (r_n == '0);
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd5) begin
                        r_st <= (r_n == '0) ? S_IDLE : S_RDH;
                    end
                end
                S_RDH: begin
                    r_i <= r_i + 1'b1;
                    r_st <= S_COPY;
                end
                S_COPY: if (ofree) begin
                    r_ov <= 1'b1; r_ok <= 1'b0; r_oe <= 1'b0;
                    r_ob <= h_rd; r_ol <= (r_i == r_n);
                    r_i <= r_i + 1'b1;
                    if (r_i == r_n) r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_oh: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_st))
        else $error("state not one-hot");
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_len <= LMax)
        else $error("line overflow");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> (r_ov && $stable(r_ob))) else $error("result lost");
endmodule

@@ src/line_editor_with_history.sv @@
// terminal line editor with command history. one item is either a received byte
// (i_action 0) or a timer tick (i_action 1). beats on the output carry terminal echo
// (o_out_kind 0) or command bytes for the dispatcher (o_out_kind 1, o_cmd_end on the
// final one); o_last marks the final beat caused by an input. a two-entry queue
// decouples the byte classifier from the executor. the executor emits at most one beat
// per cycle, and none while the output is stalled; it takes a new queue entry only when
// idle and drives all beats from a single output register fed by the line and history
// memories. ticks and silent bytes produce no output.
module line_editor_with_history #(
    parameter int LineLen   = led_pkg::LineLen,
    parameter int HistDepth = led_pkg::HistDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_kind,
    output logic       o_cmd_end,
    output logic       o_last
);
    logic          q_valid, q_stall;
    led_pkg::t_cmd q_cmd;

    // front: escape tracking and byte classification
    led_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_action), .i_rx_byte(i_rx_byte),
        .o_q_valid(q_valid), .i_q_stall(q_stall), .o_q_cmd(q_cmd)
    );

    // back: line, history and echo generation
    led_back #(.LineLen(LineLen), .HistDepth(HistDepth)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_stall(q_stall), .i_q_cmd(q_cmd),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_byte(o_out_byte), .o_out_kind(o_out_kind),
        .o_cmd_end(o_cmd_end), .o_last(o_last)
    );
endmodule
